/* rtl/edge_detect_3x3_threshold_unit_macros.svh */
// assertion helpers shared by the edge detector rtl
`ifndef EDGE_DETECT_3X3_THRESHOLD_UNIT_MACROS_SVH
`define EDGE_DETECT_3X3_THRESHOLD_UNIT_MACROS_SVH

// property checked every cycle outside reset
`define ED3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies a result in the next
`define ED3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ed3_pkg.sv */
package ed3_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int MIN_WIDTH = 3;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int WID_W     = 11;
  localparam int PIX_W     = 8;
  localparam int MEM_W     = 2 * PIX_W;
  localparam int GRAD_W    = PIX_W + 3;
  localparam int LAP_W     = PIX_W + 5;
  localparam int SQ_W      = 2 * GRAD_W - 2;
  localparam int SUM_W     = SQ_W + 1;

  localparam int MAG_SQ_LIMIT = 16256;
  localparam int LAP_LIMIT    = 128;

  localparam logic [WID_W-1:0] LINE_WIDTH_RST = WID_W'(640);

  typedef enum logic [1:0] {
    MODE_ROBERTS = 2'd0,
    MODE_PREWITT = 2'd1,
    MODE_SOBEL   = 2'd2,
    MODE_LAPLACE = 2'd3
  } mode_t;

  typedef enum logic {
    REG_KERNEL_MODE = 1'b0,
    REG_LINE_WIDTH  = 1'b1
  } reg_idx_t;

  // one window column, top row first
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  // load strobes for the kernel pipeline
  typedef struct packed {
    logic grad;
    logic sq;
  } ld_t;

endpackage

/* rtl/ed3_cell.sv */
module ed3_cell (
  input  logic          clk,
  input  logic          en,
  input  ed3_pkg::col_t col_in,
  output ed3_pkg::col_t col_out
);

  ed3_pkg::col_t col_r;

  always_ff @(posedge clk) begin
    if (en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

endmodule

/* rtl/ed3_kernel.sv */
module ed3_kernel (
  input  logic           clk,
  input  ed3_pkg::ld_t   ld,
  input  ed3_pkg::mode_t mode,
  input  ed3_pkg::col_t  w0,
  input  ed3_pkg::col_t  w1,
  input  ed3_pkg::col_t  w2,
  output logic           hit
);

  localparam int GX = ed3_pkg::GRAD_W;
  localparam int LX = ed3_pkg::LAP_W;
  localparam int PW = ed3_pkg::PIX_W;

  logic signed [GX-1:0] gx_nxt, gy_nxt, gx_r, gy_r;
  logic signed [LX-1:0] lap_val;
  logic                 lap_nxt, lap_r, lap_s4_r;
  logic signed [2*GX-1:0] gx_sq, gy_sq;
  logic [ed3_pkg::SQ_W-1:0]  gx_sq_r, gy_sq_r;
  logic [ed3_pkg::SUM_W-1:0] mag_sq;

  function automatic logic signed [GX-1:0] g1(input logic [PW-1:0] p);
    return $signed({{(GX-PW){1'b0}}, p});
  endfunction

  function automatic logic signed [GX-1:0] g2(input logic [PW-1:0] p);
    return $signed({{(GX-PW-1){1'b0}}, p, 1'b0});
  endfunction

  function automatic logic signed [LX-1:0] l1(input logic [PW-1:0] p);
    return $signed({{(LX-PW){1'b0}}, p});
  endfunction

  always_comb begin
    case (mode)
      ed3_pkg::MODE_ROBERTS: begin
        gx_nxt = g1(w2.bot) - g1(w1.mid);
        gy_nxt = g1(w1.bot) - g1(w2.mid);
      end
      ed3_pkg::MODE_PREWITT: begin
        gx_nxt = (g1(w0.bot) + g1(w1.bot) + g1(w2.bot))
               - (g1(w0.top) + g1(w1.top) + g1(w2.top));
        gy_nxt = (g1(w2.top) + g1(w2.mid) + g1(w2.bot))
               - (g1(w0.top) + g1(w0.mid) + g1(w0.bot));
      end
      ed3_pkg::MODE_SOBEL: begin
        gx_nxt = (g1(w0.bot) + g2(w1.bot) + g1(w2.bot))
               - (g1(w0.top) + g2(w1.top) + g1(w2.top));
        gy_nxt = (g1(w2.top) + g2(w2.mid) + g1(w2.bot))
               - (g1(w0.top) + g2(w0.mid) + g1(w0.bot));
      end
      default: begin
        gx_nxt = '0;
        gy_nxt = '0;
      end
    endcase
  end

  // eight times the centre minus the eight neighbors
  assign lap_val = (l1(w1.mid) <<< 3)
                 - (l1(w0.top) + l1(w1.top) + l1(w2.top) + l1(w0.mid)
                  + l1(w2.mid) + l1(w0.bot) + l1(w1.bot) + l1(w2.bot));
  assign lap_nxt = lap_val >= LX'(ed3_pkg::LAP_LIMIT);

  always_ff @(posedge clk) begin
    if (ld.grad) begin
      gx_r  <= gx_nxt;
      gy_r  <= gy_nxt;
      lap_r <= lap_nxt;
    end
  end

  assign gx_sq = gx_r * gx_r;
  assign gy_sq = gy_r * gy_r;

  always_ff @(posedge clk) begin
    if (ld.sq) begin
      gx_sq_r  <= gx_sq[ed3_pkg::SQ_W-1:0];
      gy_sq_r  <= gy_sq[ed3_pkg::SQ_W-1:0];
      lap_s4_r <= lap_r;
    end
  end

  assign mag_sq = {1'b0, gx_sq_r} + {1'b0, gy_sq_r};
  assign hit = (mode == ed3_pkg::MODE_LAPLACE) ? lap_s4_r
             : (mag_sq > ed3_pkg::SUM_W'(ed3_pkg::MAG_SQ_LIMIT));

endmodule

/* rtl/edge_detect_3x3_threshold_unit.sv */
// path from input transaction to out_valid: stages s1, s2, s3 and s4, then the output register; out_ready low stalls it
// throughput: one pixel per cycle while not stalled, set by the single-port-per-side line memory and window cells
// reset: kernel_mode 2, line_width 640, counters and pipeline cleared
// after reset a clearing pass zeroes all 1024 line memory entries with in_ready low
// configuration writes are taken at any time, also during the clearing pass
`include "edge_detect_3x3_threshold_unit_macros.svh"

module edge_detect_3x3_threshold_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [ed3_pkg::WID_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ed3_pkg::PIX_W-1:0]   in_pixel,
  input  logic                        in_frame_start,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_edge_res,
  output logic                        out_centre_valid
);

  localparam int AW = ed3_pkg::ADDR_W;
  localparam int WW = ed3_pkg::WID_W;
  localparam int PW = ed3_pkg::PIX_W;
  localparam int MW = ed3_pkg::MEM_W;

  // configuration
  ed3_pkg::mode_t  kernel_mode_r;
  logic [WW-1:0]   line_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_mode_r <= ed3_pkg::MODE_SOBEL;
      line_width_r  <= ed3_pkg::LINE_WIDTH_RST;
    end else if (cfg_we) begin
      case (ed3_pkg::reg_idx_t'(cfg_index))
        ed3_pkg::REG_KERNEL_MODE: kernel_mode_r <= ed3_pkg::mode_t'(cfg_wdata[1:0]);
        ed3_pkg::REG_LINE_WIDTH:  line_width_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline occupancy and flow
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_valid_r;
  logic out_free, s4_free, s3_free, s2_free, s1_free;
  logic in_acc, ld_s2;
  ed3_pkg::ld_t ld;
  logic clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  assign out_free = !out_valid_r || out_ready;
  assign s4_free  = !s4_v_r || out_free;
  assign s3_free  = !s3_v_r || s4_free;
  assign s2_free  = !s2_v_r || s3_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ready = !clr_busy_r && s1_free;
  assign in_acc   = in_valid && in_ready;
  assign ld_s2    = s1_v_r && s2_free;
  assign ld.grad  = s2_v_r && s3_free;
  assign ld.sq    = s3_v_r && s4_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free)  s1_v_r      <= in_acc;
      if (s2_free)  s2_v_r      <= s1_v_r;
      if (s3_free)  s3_v_r      <= s2_v_r;
      if (s4_free)  s4_v_r      <= s3_v_r;
      if (out_free) out_valid_r <= s4_v_r;
    end
  end

  // column and row tracking at the input
  logic [AW-1:0] column_count_r, column_count_nxt, col_cur;
  logic [1:0]    row_count_r, row_count_nxt, row_cur;
  logic [WW-1:0] width_eff, col_inc;
  logic          row_end, centre_ok;

  always_comb begin
    if (line_width_r < WW'(ed3_pkg::MIN_WIDTH)) begin
      width_eff = WW'(ed3_pkg::MIN_WIDTH);
    end else if (line_width_r > WW'(ed3_pkg::MAX_WIDTH)) begin
      width_eff = WW'(ed3_pkg::MAX_WIDTH);
    end else begin
      width_eff = line_width_r;
    end
    col_cur   = in_frame_start ? '0 : column_count_r;
    row_cur   = in_frame_start ? '0 : row_count_r;
    col_inc   = {{(WW-AW){1'b0}}, col_cur} + WW'(1);
    row_end   = col_inc >= width_eff;
    centre_ok = (row_cur >= 2'd2) && (col_cur >= AW'(2));
    column_count_nxt = row_end ? '0 : col_inc[AW-1:0];
    row_count_nxt    = (row_end && row_cur < 2'd2) ? row_cur + 2'd1 : row_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      row_count_r    <= '0;
    end else if (in_acc) begin
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
    end
  end

  // line memory: upper half older row, lower half newer row
  logic [MW-1:0] line_mem [ed3_pkg::MAX_WIDTH];
  logic [MW-1:0] mem_rd_r, mem_wdata, s1_fwd_data_r, s1_rd;
  logic [AW-1:0] mem_waddr, s1_addr_r;
  logic          mem_we, s1_wr, s1_fwd_r, s1_ctr_r;
  logic [PW-1:0] s1_pix_r;

  assign s1_wr     = s1_v_r && s2_free;
  assign s1_rd     = s1_fwd_r ? s1_fwd_data_r : mem_rd_r;
  assign mem_we    = clr_busy_r || s1_wr;
  assign mem_waddr = clr_busy_r ? clr_addr_r : s1_addr_r;
  assign mem_wdata = clr_busy_r ? '0 : {s1_rd[PW-1:0], s1_pix_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      mem_rd_r <= line_mem[col_cur];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(ed3_pkg::MAX_WIDTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // same column written back in this cycle: take the write data instead
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_fwd_r <= 1'b0;
    end else if (s1_free) begin
      s1_fwd_r <= in_acc && s1_wr && (s1_addr_r == col_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr_r     <= col_cur;
      s1_pix_r      <= in_pixel;
      s1_ctr_r      <= centre_ok;
      s1_fwd_data_r <= {s1_rd[PW-1:0], s1_pix_r};
    end
  end

  // window: chain of three column cells, newest on the right
  ed3_pkg::col_t col_new, win0, win1, win2;
  logic s2_ctr_r, s3_ctr_r, s4_ctr_r;

  assign col_new.top = s1_rd[MW-1:PW];
  assign col_new.mid = s1_rd[PW-1:0];
  assign col_new.bot = s1_pix_r;

  ed3_cell u_cell2 (.clk(clk), .en(ld_s2), .col_in(col_new), .col_out(win2));
  ed3_cell u_cell1 (.clk(clk), .en(ld_s2), .col_in(win2),    .col_out(win1));
  ed3_cell u_cell0 (.clk(clk), .en(ld_s2), .col_in(win1),    .col_out(win0));

  always_ff @(posedge clk) begin
    if (ld_s2)   s2_ctr_r <= s1_ctr_r;
    if (ld.grad) s3_ctr_r <= s2_ctr_r;
    if (ld.sq)   s4_ctr_r <= s3_ctr_r;
  end

  logic hit;

  ed3_kernel u_kernel (
    .clk  (clk),
    .ld   (ld),
    .mode (kernel_mode_r),
    .w0   (win0),
    .w1   (win1),
    .w2   (win2),
    .hit  (hit)
  );

  logic out_edge_res_r, out_centre_valid_r;

  always_ff @(posedge clk) begin
    if (s4_v_r && out_free) begin
      out_edge_res_r     <= s4_ctr_r && hit;
      out_centre_valid_r <= s4_ctr_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_edge_res     = out_edge_res_r;
  assign out_centre_valid = out_centre_valid_r;

  `ED3_ASSERT(a_no_accept_clr, clr_busy_r |-> (!in_ready && !s1_v_r), "transaction during clear")
  `ED3_ASSERT(a_row_sat, row_count_r != 2'd3, "row count past saturation")
  `ED3_ASSERT(a_edge_ctr, out_valid_r |-> (!out_edge_res_r || out_centre_valid_r), "edge on border")
  `ED3_ASSERT(a_fwd_occ, s1_fwd_r |-> s1_v_r, "forward flag without stage item")
  `ED3_ASSERT_NEXT(a_clr_end, clr_busy_r && clr_addr_r == AW'(ed3_pkg::MAX_WIDTH - 1), !clr_busy_r, "clear did not end")

endmodule
